// File: src/srpu_pkg.sv
// Package of shared constants and types for the propensity update unit.
`timescale 1ns / 1ps
package srpu_pkg;
    localparam int SURFACE_SPECIES = 8;
    localparam int VOLUME_SPECIES  = 8;
    localparam int COUNT_BITS      = 16;
    localparam int MAX_ORDER       = 4;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_PROP  = 2'd2;
    localparam logic [1:0] ACT_FIRE  = 2'd3;

    localparam logic [1:0] COMP_SURF  = 2'd0;
    localparam logic [1:0] COMP_INNER = 2'd1;
    localparam logic [1:0] COMP_OUTER = 2'd2;

    localparam logic [2:0] CFG_RATE  = 3'd0;
    localparam logic [2:0] CFG_FLAGS = 3'd1;
    localparam logic [2:0] CFG_SORD  = 3'd2;
    localparam logic [2:0] CFG_VORD  = 3'd3;
    localparam logic [2:0] CFG_SDEL  = 3'd4;
    localparam logic [2:0] CFG_IDEL  = 3'd5;
    localparam logic [2:0] CFG_ODEL  = 3'd6;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_SAT   = 3'd3;
    localparam logic [2:0] ST_ORDER = 3'd4;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] compartment;
        logic [2:0] species;
        logic [15:0] count_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0] count_out;
        logic [63:0] combinations;
        logic [63:0] propensity;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [2:0] index;
        logic [63:0] data;
    } cfg_item_t;
endpackage

// File: src/srpu_if.sv
// Valid/ready channel interfaces for items and configuration writes.
`timescale 1ns / 1ps
interface srpu_in_if;
    logic valid;
    logic ready;
    srpu_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srpu_out_if;
    logic valid;
    logic ready;
    srpu_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srpu_cfg_if;
    logic valid;
    logic ready;
    srpu_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/surface_reaction_propensity_update_unit.sv
// Top level of the surface reaction propensity update unit.
`timescale 1ns / 1ps
// Usage: items arrive on the in channel (action, compartment, species,
// count_in) and each gives exactly one result item on the out channel.
// Configuration registers are written on the cfg channel, index i names
// register i, and must only be written while the unit is idle; the block
// itself does not enforce this. A write or read of a count passes from
// idle through the done state to a result. A fire item updates one
// species per cycle over the three compartments. A propensity item walks
// the 8 surface species, and the 8 volume species when a volume side is
// read, and for each factor of its falling factorial runs a bit-serial 64
// by 64 multiplication; a final multiplication scales by the rate
// constant. The shared bit-serial multiplier sets the pace.
// One item is worked on at a time. The result waits in an output register
// while the receiver stalls, and no new item is taken until it leaves; the
// next item can be taken in the same cycle as the waiting result leaves.
// Reset clears all counts, the configuration registers, the output valid
// flag and the control state at once.
module surface_reaction_propensity_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    srpu_in_if.sink     in_ch,
    srpu_out_if.source  out_ch,
    srpu_cfg_if.sink    cfg
);
    import srpu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_FIRE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [63:0] rate_reg;
    logic [4:0]  flags_reg;
    logic [23:0] sord_reg, vord_reg;
    logic [63:0] sdel_reg, idel_reg, odel_reg;
    count_t      scnt_reg [SURFACE_SPECIES];
    count_t      icnt_reg [VOLUME_SPECIES];
    count_t      ocnt_reg [VOLUME_SPECIES];

    logic [2:0]  state_reg, state_next;
    in_item_t    item_reg;
    logic [4:0]  idx_reg, idx_next;       // species walk: 0..7 surface, 8..15 volume
    logic [2:0]  k_reg, k_next;           // factor within the falling factorial
    logic [63:0] prod_reg, prod_next;
    logic        sat_reg, sat_next;
    logic [1:0]  fst_reg, fst_next;
    logic        ovalid_reg;
    out_item_t   odata_reg;

    // Multiplier hook-up.
    logic        mul_start, mul_done, mul_sat;
    logic [63:0] mul_b, mul_p;

    srpu_sermul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (prod_reg),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p),
        .sat     (mul_sat)
    );

    logic use_vol, vol_inner;
    assign use_vol   = flags_reg[1] || flags_reg[2];
    assign vol_inner = flags_reg[1];

    // Order and count of the species currently addressed by the walk.
    logic [2:0] cur_ord;
    count_t     cur_cnt;
    logic [2:0] sp;
    assign sp = idx_reg[2:0];
    always_comb begin
        if (!idx_reg[3]) begin
            cur_ord = sord_reg[3*sp +: 3];
            cur_cnt = scnt_reg[sp];
        end else begin
            cur_ord = vord_reg[3*sp +: 3];
            cur_cnt = vol_inner ? icnt_reg[sp] : ocnt_reg[sp];
        end
    end

    // Order check over the sides that take part; done in one step as 16 tiny compares.
    logic bad_s, bad_v;
    always_comb begin
        bad_s = 1'b0;
        bad_v = 1'b0;
        for (int i = 0; i < SURFACE_SPECIES; i++)
            if (sord_reg[3*i +: 3] > 3'(MAX_ORDER)) bad_s = 1'b1;
        for (int i = 0; i < VOLUME_SPECIES; i++)
            if (vord_reg[3*i +: 3] > 3'(MAX_ORDER)) bad_v = 1'b1;
    end

    // Is the walk at its last species: 15 with a volume side, else 7?
    logic in_last;
    assign in_last = use_vol ? (idx_reg == 5'd15) : (idx_reg == 5'd7);

    // A multiplication started with every factor of the species done is the
    // final scaling by the rate constant.
    assign mul_b     = (k_reg == cur_ord) ? rate_reg :
                       {{(64-COUNT_BITS){1'b0}}, cur_cnt - count_t'(k_reg)};
    assign in_ch.ready = (state_reg == S_IDLE) && !(ovalid_reg && !out_ch.ready);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    logic in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;

    // Fire step on one species.
    logic [1:0]  fcomp;
    logic        fen;
    logic signed [7:0] fd;
    count_t      fold;
    logic signed [COUNT_BITS+1:0] fsum;
    count_t      fnew;
    logic [1:0]  fflag;
    always_comb begin
        fcomp = idx_reg[4:3];
        case (fcomp)
            2'd0: begin fen = 1'b1; fd = sdel_reg[8*sp +: 8]; fold = scnt_reg[sp]; end
            2'd1: begin fen = flags_reg[3]; fd = idel_reg[8*sp +: 8]; fold = icnt_reg[sp]; end
            2'd2: begin fen = flags_reg[4]; fd = odel_reg[8*sp +: 8]; fold = ocnt_reg[sp]; end
            default: begin fen = 1'b0; fd = '0; fold = '0; end
        endcase
        fsum  = $signed({2'b00, fold}) + (COUNT_BITS+2)'(fd);
        fflag = 2'b00;
        fnew  = fsum[COUNT_BITS-1:0];
        if (fsum < 0) begin
            fnew  = '0;
            fflag = 2'b01;
        end else if (fsum[COUNT_BITS]) begin
            fnew  = '1;
            fflag = 2'b10;
        end
        if (!fen || fd == 0)
            fflag = 2'b00;
    end
    logic fwrite;
    assign fwrite = (state_reg == S_FIRE) && fen && (fd != 0);

    logic       finish;
    out_item_t  res;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        sat_next   = sat_reg;
        fst_next   = fst_reg;
        mul_start  = 1'b0;
        finish     = 1'b0;
        res        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    idx_next  = '0;
                    k_next    = '0;
                    prod_next = 64'd1;
                    sat_next  = 1'b0;
                    fst_next  = '0;
                    case (in_ch.data.action)
                        ACT_PROP: state_next = S_CHECK;
                        ACT_FIRE: state_next = S_FIRE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_CHECK: begin
                if (!flags_reg[0]) begin
                    finish = 1'b1;
                end else if (bad_s || (use_vol && bad_v)) begin
                    finish = 1'b1;
                    res.status = ST_ORDER;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (k_reg == cur_ord) begin
                    k_next = '0;
                    if (in_last) begin
                        mul_start  = 1'b1;
                        state_next = S_SCALE;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end else if (k_reg == 3'd0 && count_t'(cur_ord) > cur_cnt) begin
                    finish = 1'b1;   // order above count: zero result
                end else begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    prod_next  = mul_p;
                    sat_next   = sat_reg | mul_sat;
                    k_next     = k_reg + 3'd1;
                    state_next = S_WALK;
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    finish = 1'b1;
                    res.combinations = prod_reg;
                    res.propensity   = mul_p;
                    res.status       = (sat_reg || mul_sat) ? ST_SAT : ST_OK;
                end
            end
            S_FIRE: begin
                fst_next = fst_reg | fflag;
                if (idx_reg == 5'd23) begin
                    finish = 1'b1;
                    res.status = fst_next[0] ? ST_UNDER : (fst_next[1] ? ST_OVER : ST_OK);
                end else begin
                    idx_next = (idx_reg[2:0] == 3'(VOLUME_SPECIES-1)) ?
                               {idx_reg[4:3] + 2'd1, 3'd0} : idx_reg + 5'd1;
                end
            end
            S_DONE: begin
                finish = 1'b1;
                if (item_reg.action == ACT_READ && item_reg.compartment inside {COMP_SURF, COMP_INNER, COMP_OUTER}) begin
                    case (item_reg.compartment)
                        COMP_SURF:  res.count_out = 16'(scnt_reg[item_reg.species]);
                        COMP_INNER: res.count_out = 16'(icnt_reg[item_reg.species]);
                        default:    res.count_out = 16'(ocnt_reg[item_reg.species]);
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (finish)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            rate_reg   <= '0;
            flags_reg  <= '0;
            sord_reg   <= '0;
            vord_reg   <= '0;
            sdel_reg   <= '0;
            idel_reg   <= '0;
            odel_reg   <= '0;
            for (int i = 0; i < SURFACE_SPECIES; i++) scnt_reg[i] <= '0;
            for (int i = 0; i < VOLUME_SPECIES; i++) begin
                icnt_reg[i] <= '0;
                ocnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (finish)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (cfg.valid) begin
                case (cfg.data.index)
                    CFG_RATE:  rate_reg  <= cfg.data.data;
                    CFG_FLAGS: flags_reg <= cfg.data.data[4:0];
                    CFG_SORD:  sord_reg  <= cfg.data.data[23:0];
                    CFG_VORD:  vord_reg  <= cfg.data.data[23:0];
                    CFG_SDEL:  sdel_reg  <= cfg.data.data;
                    CFG_IDEL:  idel_reg  <= cfg.data.data;
                    CFG_ODEL:  odel_reg  <= cfg.data.data;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && item_reg.action == ACT_WRITE) begin
                case (item_reg.compartment)
                    COMP_SURF:  scnt_reg[item_reg.species] <= count_t'(item_reg.count_in);
                    COMP_INNER: icnt_reg[item_reg.species] <= count_t'(item_reg.count_in);
                    COMP_OUTER: ocnt_reg[item_reg.species] <= count_t'(item_reg.count_in);
                    default: ;
                endcase
            end
            if (fwrite) begin
                case (fcomp)
                    2'd0: scnt_reg[sp] <= fnew;
                    2'd1: icnt_reg[sp] <= fnew;
                    default: ocnt_reg[sp] <= fnew;
                endcase
            end
        end
    end

    always_ff @(posedge clk) begin
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        sat_reg  <= sat_next;
        fst_reg  <= fst_next;
        if (in_acc)
            item_reg <= in_ch.data;
        if (finish)
            odata_reg <= res;
    end

    assert property (@(posedge clk) disable iff (!rst_n) finish |=> out_ch.valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |-> state_reg == S_IDLE)
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(odata_reg))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n) finish |-> !(ovalid_reg && !out_ch.ready))
        else $error("result overwritten");
endmodule

// File: src/srpu_sermul.sv
// Bit-serial 64 by 64 saturating multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module srpu_sermul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product,
    output logic        sat
);
    import srpu_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] mplier_reg, mplier_next;
    logic        ovf_reg, ovf_next;
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] sum;

    // Processes the multiplier from its top bit: acc = 2*acc + bit*mcand.
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        ovf_next    = ovf_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        sum         = '0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            ovf_next    = 1'b0;
            busy_next   = 1'b1;
            cnt_next    = 7'd64;
        end else if (busy_reg) begin
            sum = {acc_reg, 1'b0} + (mplier_reg[63] ? {1'b0, mcand_reg} : 65'd0);
            if (acc_reg[63] || sum[64])
                ovf_next = 1'b1;
            acc_next    = sum[63:0];
            mplier_next = {mplier_reg[62:0], 1'b0};
            cnt_next    = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        ovf_reg    <= ovf_next;
    end

    assign done    = busy_reg && (cnt_reg == 7'd1) && !start;
    assign product = (ovf_next) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_next;
    assign sat     = ovf_next;

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy_reg)
        else $error("multiplier still busy after done");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg && cnt_reg == 7'd64)
        else $error("multiplier did not start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg && !start |=> $past(cnt_reg) - 7'd1 == cnt_reg || !busy_reg)
        else $error("multiplier counter slipped");
endmodule
